// ===== design/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and codes for the life grid generation step block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Input field widths
  localparam int CMD_W = 2;
  localparam int ROW_W = 6;
  localparam int COL_W = 6;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PLACE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] ROWS_IN_USE_RST = 7'd64;
  localparam logic [CFG_DATA_W-1:0] COLS_IN_USE_RST = 7'd64;

  // Control that the sequencer broadcasts to every column cell
  typedef struct packed {
    logic clear;    // empty the window before a generation starts
    logic shift;    // move the window down by one row
    logic zero_in;  // the incoming row lies below the grid in use
  } lgs_cell_ctrl_t;

  // Window bits that a cell shows its neighbors, gated by column enable
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } lgs_win_t;

endpackage

// ===== design/lgs_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_cell
// One grid column: holds a three-row window of that column and computes the
// next state of the center cell from its own and its neighbors' windows.
// ----------------------------------------------------------------------------
module lgs_cell
  import lgs_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lgs_cell_ctrl_t ctrl_i,
  input  logic           en_i,
  input  logic           dn_i,
  input  lgs_win_t       left_i,
  input  lgs_win_t       right_i,
  output lgs_win_t       win_o,
  output logic           next_o
);

  logic       up_q;
  logic       mid_q;
  logic       dn;
  logic [3:0] count;
  logic       rule;

  // Drop the incoming row past the last row in use
  assign dn = dn_i & ~ctrl_i.zero_in;

  // Show only columns in use to the neighbors
  assign win_o.up  = up_q & en_i;
  assign win_o.mid = mid_q & en_i;
  assign win_o.dn  = dn & en_i;

  // Count the eight neighbors and apply B3/S23
  assign count = 4'(left_i.up) + 4'(left_i.mid) + 4'(left_i.dn)
               + 4'(right_i.up) + 4'(right_i.mid) + 4'(right_i.dn)
               + 4'(up_q) + 4'(dn);
  assign rule  = (count == 4'd3) | (mid_q & (count == 4'd2));

  // Keep the stored value of a column outside the grid in use
  assign next_o = en_i ? rule : mid_q;

  // Advance the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q  <= 1'b0;
      mid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      up_q  <= 1'b0;
      mid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      up_q  <= mid_q;
      mid_q <= dn;
    end
  end

endmodule

// ===== design/life_grid_generation_step.sv =====
// Order: place and read answer via the registered row read, then the result
// register; an out-of-range or unused command, or advance when the row count in
// use (saturated to MAX_ROWS) is zero, answers from the result register alone.
// Throughput: one command at a time; advance walks the row memory one row per
// cycle through its single read port, feeding the row of column cells.
// Reset: a clearing pass writes every row dead with busy high;
// results come out on a one-cycle strobe and the receiver cannot stall.
// ----------------------------------------------------------------------------
// life_grid_generation_step
// Bounded B3/S23 life grid with place, read and advance-one-generation
// commands over a row memory and a chain of column cells.
// ----------------------------------------------------------------------------
module life_grid_generation_step
  import lgs_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [COL_W-1:0]      col_i,
  output logic                  done_o,
  output logic                  alive_o,
  output logic                  status_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int CIW  = $clog2(MAX_COLS);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int RCMP = (RCW > CFG_DATA_W) ? RCW : CFG_DATA_W;
  localparam int CCMP = (CCW > CFG_DATA_W) ? CCW : CFG_DATA_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ACC   = 2'd2;
  localparam logic [1:0] ST_ADV   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [RCW-1:0]        cnt_q, cnt_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [AW-1:0]         row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic                  done_q, done_d;
  logic                  alive_q, alive_d;
  logic                  status_q, status_d;
  logic [CFG_DATA_W-1:0] rows_q, cols_q;

  logic [MAX_COLS-1:0]   mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0]   rdata_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0]   mem_wdata;

  logic [RCMP-1:0]       eff_rows_c;
  logic [CCMP-1:0]       eff_cols_c;
  logic [RCW-1:0]        nrows;
  logic                  in_range;
  logic                  accept;
  logic [RCW:0]          cnt_inc;
  logic [RCW-1:0]        cnt_dec;
  logic [CIW-1:0]        col_idx;

  lgs_cell_ctrl_t        cell_ctrl;
  lgs_win_t              cell_win [MAX_COLS];
  logic [MAX_COLS-1:0]   col_en;
  logic [MAX_COLS-1:0]   next_row;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign alive_o     = alive_q;
  assign status_o    = status_q;

  // Saturate the grid size to the store size
  always_comb begin
    eff_rows_c = (RCMP'(rows_q) > RCMP'(MAX_ROWS)) ? RCMP'(MAX_ROWS) : RCMP'(rows_q);
    eff_cols_c = (CCMP'(cols_q) > CCMP'(MAX_COLS)) ? CCMP'(MAX_COLS) : CCMP'(cols_q);
  end

  assign nrows    = RCW'(eff_rows_c);
  assign in_range = (RCMP'(row_i) < eff_rows_c) && (CCMP'(col_i) < eff_cols_c);
  assign cnt_inc  = (RCW + 1)'(cnt_q) + (RCW + 1)'(1);
  assign cnt_dec  = cnt_q - RCW'(1);
  assign col_idx  = CIW'(col_q);

  // Capture configuration transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_IN_USE_RST;
      cols_q <= COLS_IN_USE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ROWS_IN_USE: rows_q <= cfg_data_i;
        REG_COLS_IN_USE: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequence commands, the clearing pass and the generation walk
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    row_d     = row_q;
    col_d     = col_q;
    done_d    = 1'b0;
    alive_d   = 1'b0;
    status_d  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = row_q;
    mem_raddr = AW'(row_i);
    mem_wdata = '0;
    cell_ctrl = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        if (cnt_q == RCW'(MAX_ROWS - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + RCW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d = cmd_i;
          row_d = AW'(row_i);
          col_d = col_i;
          case (cmd_i)
            CMD_PLACE, CMD_READ: begin
              if (in_range) begin
                mem_re  = 1'b1;
                state_d = ST_ACC;
              end else begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end
            end
            CMD_ADVANCE: begin
              if (nrows == '0) begin
                done_d = 1'b1;
              end else begin
                mem_re          = 1'b1;
                mem_raddr       = '0;
                cell_ctrl.clear = 1'b1;
                cnt_d           = '0;
                state_d         = ST_ADV;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_ACC: begin
        // Finish the read-modify-write or answer the read
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (cmd_q == CMD_PLACE) begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | (MAX_COLS'(1) << col_idx);
        end else begin
          alive_d = rdata_q[col_idx];
        end
      end
      ST_ADV: begin
        // Row cnt enters the window; row cnt-1 is written back
        cell_ctrl.shift   = 1'b1;
        cell_ctrl.zero_in = (cnt_q == nrows);
        mem_re            = (cnt_inc < (RCW + 1)'(nrows));
        mem_raddr         = cnt_inc[AW-1:0];
        mem_we            = (cnt_q != '0);
        mem_waddr         = cnt_dec[AW-1:0];
        mem_wdata         = next_row;
        if (cnt_q == nrows) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc[RCW-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Hold the command and result payload
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    row_q    <= row_d;
    col_q    <= col_d;
    alive_q  <= alive_d;
    status_q <= status_d;
  end

  // Row memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Chain of column cells
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    lgs_win_t left_win;
    lgs_win_t right_win;

    assign col_en[c] = (CCMP'(c) < eff_cols_c);

    if (c == 0) begin : g_left_edge
      assign left_win = '0;
    end else begin : g_left
      assign left_win = cell_win[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_right_edge
      assign right_win = '0;
    end else begin : g_right
      assign right_win = cell_win[c+1];
    end

    lgs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .en_i    (col_en[c]),
      .dn_i    (rdata_q[c]),
      .left_i  (left_win),
      .right_i (right_win),
      .win_o   (cell_win[c]),
      .next_o  (next_row[c])
    );
  end

`ifndef SYNTHESIS
  // A generation never writes the row it is about to read
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("row memory read and write at the same address");

  // An accepted command either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted command neither answered nor in progress");

  // No result during the clearing pass
  a_no_done_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !done_o)
    else $error("result strobe during clearing pass");

  // An error result never reports a live cell
  a_err_not_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> !alive_o)
    else $error("error result with alive set");
`endif

endmodule

// ===== verif/life_grid_generation_step_tb.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step_tb
// Self-checking bench for the life grid block. A driver transfers commands
// from a queue, a predictor mirrors the grid and the two size registers, and
// a monitor compares every strobed answer with the oldest predicted one.
// ----------------------------------------------------------------------------
module life_grid_generation_step_tb
  import lgs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  // Codes the package does not name
  localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } grid_cmd_t;

  typedef struct {
    logic alive;
    logic status;
  } grid_answer_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [CMD_W-1:0]      cmd_i       = '0;
  logic [ROW_W-1:0]      row_i       = '0;
  logic [COL_W-1:0]      col_i       = '0;
  logic                  done_o;
  logic                  alive_o;
  logic                  status_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  grid_cmd_t    cmd_queue[$];
  grid_answer_t answer_queue[$];
  grid_cmd_t    next_cmd;
  grid_answer_t got_answer;
  int           idle_pct;
  int           error_count = 0;
  int           quiet_cycles = 0;

  // Mirror of the block's state
  logic [GRID_COLS-1:0]  life_cells [GRID_ROWS];
  logic [CFG_DATA_W-1:0] rows_reg = ROWS_IN_USE_RST;
  logic [CFG_DATA_W-1:0] cols_reg = COLS_IN_USE_RST;

  life_grid_generation_step #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .done_o     (done_o),
    .alive_o    (alive_o),
    .status_o   (status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int r = 0; r < GRID_ROWS; r++) life_cells[r] = '0;
  end

  // Saturate the size registers to the store size
  function automatic int used_rows();
    return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
  endfunction

  function automatic int used_cols();
    return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
  endfunction

  // Compute one B3/S23 generation over the area in use, no wrap-around
  function automatic void step_generation();
    logic [GRID_COLS-1:0] next_cells [GRID_ROWS];
    int nr, nc, live, rr, cc;
    nr = used_rows();
    nc = used_cols();
    next_cells = life_cells;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc &&
                life_cells[rr][cc])
              live++;
          end
        end
        if (life_cells[r][c]) next_cells[r][c] = (live == 2 || live == 3);
        else                  next_cells[r][c] = (live == 3);
      end
    end
    life_cells = next_cells;
  endfunction

  // Apply one command to the mirror and return the answer it gives
  function automatic grid_answer_t predict_grid_cmd(grid_cmd_t c);
    grid_answer_t ans;
    ans.alive  = 1'b0;
    ans.status = 1'b0;
    case (c.cmd)
      CMD_PLACE, CMD_READ: begin
        if (c.row >= used_rows() || c.col >= used_cols()) begin
          ans.status = 1'b1;
        end else if (c.cmd == CMD_PLACE) begin
          life_cells[c.row][c.col] = 1'b1;
        end else begin
          ans.alive = life_cells[c.row][c.col];
        end
      end
      CMD_ADVANCE: step_generation();
      default: ;
    endcase
    return ans;
  endfunction

  // Driver: predict on each transfer, then present the next command or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        answer_queue.insert(answer_queue.size(), predict_grid_cmd('{cmd_i, row_i, col_i}));
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_cmd = cmd_queue.pop_front();
          start <= 1'b1;
          cmd_i <= next_cmd.cmd;
          row_i <= next_cmd.row;
          col_i <= next_cmd.col;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed answer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (answer_queue.size() == 0) begin
        $display("%0t: answer with nothing pending: alive %0b status %0b",
                 $time, alive_o, status_o);
        error_count++;
      end else begin
        got_answer = answer_queue.pop_front();
        if (alive_o !== got_answer.alive) begin
          $display("%0t: alive mismatch: expected %0b actual %0b",
                   $time, got_answer.alive, alive_o);
          error_count++;
        end
        if (status_o !== got_answer.status) begin
          $display("%0t: status mismatch: expected %0b actual %0b",
                   $time, got_answer.status, status_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("life_grid_generation_step_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int row, input int col);
    cmd_queue.insert(cmd_queue.size(), '{cmd, row[ROW_W-1:0], col[COL_W-1:0]});
  endtask

  // Hold until every command is answered and the block is quiet
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_queue.size() != 0 || answer_queue.size() != 0 || start || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROWS_IN_USE) rows_reg = val;
    else if (idx == REG_COLS_IN_USE) cols_reg = val;
  endtask

  task automatic set_grid(input int rows, input int cols, input int pct);
    wait_drained();
    write_reg(REG_ROWS_IN_USE, rows[CFG_DATA_W-1:0]);
    write_reg(REG_COLS_IN_USE, cols[CFG_DATA_W-1:0]);
    @(negedge clk_i);
    idle_pct = pct;
  endtask

  // Mostly seeded patterns that evolve and get probed, some raw noise
  task automatic fill_random(input int n_items);
    int added, nr, nc, h, w, r0, c0, n_place, n_gen, n_read, rr, cc;
    added = 0;
    nr = used_rows();
    nc = used_cols();
    while (added < n_items) begin
      if (nr == 0 || nc == 0 || $urandom_range(99) < 20) begin
        add_cmd(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                $urandom_range(0, 63));
        added++;
      end else begin
        h = $urandom_range(1, (nr < 8) ? nr : 8);
        w = $urandom_range(1, (nc < 8) ? nc : 8);
        r0 = $urandom_range(0, nr - h);
        c0 = $urandom_range(0, nc - w);
        // pull the pattern against the border now and then
        if ($urandom_range(3) == 0) r0 = $urandom_range(1) ? 0 : nr - h;
        if ($urandom_range(3) == 0) c0 = $urandom_range(1) ? 0 : nc - w;
        n_place = $urandom_range(1, h * w / 2 + 1);
        repeat (n_place) begin
          add_cmd(CMD_PLACE, r0 + $urandom_range(0, h - 1), c0 + $urandom_range(0, w - 1));
          added++;
        end
        n_gen = $urandom_range(1, 3);
        repeat (n_gen) begin
          add_cmd(CMD_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63));
          added++;
          n_read = $urandom_range(2, 6);
          repeat (n_read) begin
            rr = r0 - 1 + $urandom_range(0, h + 1);
            cc = c0 - 1 + $urandom_range(0, w + 1);
            if (rr < 0) rr = 0;
            if (rr > 63) rr = 63;
            if (cc < 0) cc = 0;
            if (cc > 63) cc = 63;
            add_cmd(CMD_READ, rr, cc);
            added++;
          end
        end
      end
    end
  endtask

  initial begin
    idle_pct = 23;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Corners, a blinker and the unused command on the full grid
    add_cmd(CMD_PLACE, 0, 0);
    add_cmd(CMD_PLACE, 63, 63);
    add_cmd(CMD_PLACE, 0, 63);
    add_cmd(CMD_PLACE, 63, 0);
    add_cmd(CMD_READ, 0, 0);
    add_cmd(CMD_READ, 63, 63);
    add_cmd(CMD_READ, 1, 1);
    add_cmd(CMD_PLACE, 10, 10);
    add_cmd(CMD_PLACE, 10, 11);
    add_cmd(CMD_PLACE, 10, 12);
    add_cmd(CMD_ADVANCE, 0, 0);
    add_cmd(CMD_READ, 9, 11);
    add_cmd(CMD_READ, 10, 11);
    add_cmd(CMD_READ, 11, 11);
    add_cmd(CMD_READ, 10, 10);
    add_cmd(CMD_UNUSED, 63, 63);
    add_cmd(CMD_READ, 63, 63);

    // Small grid: out-of-range on each axis, then the last cell in use
    set_grid(3, 5, 23);
    add_cmd(CMD_PLACE, 3, 0);
    add_cmd(CMD_PLACE, 0, 5);
    add_cmd(CMD_READ, 2, 4);
    add_cmd(CMD_PLACE, 2, 4);
    add_cmd(CMD_READ, 2, 4);
    add_cmd(CMD_ADVANCE, 0, 0);
    add_cmd(CMD_READ, 2, 4);
    fill_random(60);

    // Empty grid on either axis
    set_grid(0, 10, 23);
    add_cmd(CMD_PLACE, 0, 0);
    add_cmd(CMD_READ, 0, 0);
    add_cmd(CMD_ADVANCE, 0, 0);
    fill_random(10);
    set_grid(10, 0, 23);
    fill_random(10);

    // Register values above the store size saturate
    set_grid(127, 127, 64);
    fill_random(100);
    set_grid(1, 1, 64);
    fill_random(30);
    set_grid(64, 65, 64);
    fill_random(60);
    set_grid(2, 64, 64);
    fill_random(40);

    // Random sizes with no sender gaps; poke the unmapped indexes too
    for (int p = 0; p < 4; p++) begin
      set_grid($urandom_range(1, 80), $urandom_range(1, 80), 0);
      if (p == 1) begin
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 127)));
        @(negedge clk_i);
      end
      fill_random(70);
    end

    wait_drained();
    repeat (70) @(posedge clk_i);
    if (answer_queue.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, answer_queue.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("life_grid_generation_step_tb: PASS");
    end else begin
      $display("life_grid_generation_step_tb: FAIL");
    end
    $finish;
  end

endmodule
